// ===== hdl/mbps_pkg.sv =====
package mbps_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LOW      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_MID_LOW  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_MID_HIGH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_HIGH     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CARE_MASK    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN      = 3'd5;

    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned OUT_OFFSET_W = 32;
    localparam int unsigned PAT_SLOTS    = 32;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
    } result_t;

endpackage

// ===== hdl/masked_byte_pattern_scanner.sv =====
// Channel   | Dir | Handshake                | Payload
// ----------+-----+--------------------------+---------------------------------------
// s_ (in)   | in  | s_tvalid / s_tready      | s_tdata = data_byte, s_tlast = region_last
// m_ (out)  | out | m_tvalid / m_tready      | m_tdata = match_offset, m_tuser = found
// cfg       | in  | cfg_valid / cfg_ready    | cfg_addr = register index, cfg_data
//
// One byte per cycle: every byte enters the cell chain and is compared against the
// aligned pattern in the same cycle; a result is registered in the output buffer before it shows on m_.
// A two-entry output buffer lets bytes keep flowing while a result waits; s_tready
// drops only while both entries are full, and for one cycle after each cfg write
// while the per-cell aligned pattern is rebuilt. Reset is synchronous, active low:
// it clears window, byte count, reported flag and output buffer; registers go to
// pattern zero, care mask all ones, length one.
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int unsigned MAX_PATTERN_BYTES = 32,
    parameter int unsigned OFFSET_BITS       = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    input  logic                  s_tlast,    // region_last
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] match_offset
    output logic [0:0]            m_tuser,    // [0] found
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned NCELL = MAX_PATTERN_BYTES;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

    // ---------------- configuration registers ----------------
    logic [PAT_SLOTS*8-1:0] pat_reg;      // byte j at [8j+7:8j]
    logic [PAT_SLOTS-1:0]   care_reg;
    logic [LEN_W-1:0]       len_cfg_reg;
    logic                   cfg_dirty_reg;
    logic                   cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg       <= '0;
            care_reg      <= '1;
            len_cfg_reg   <= LEN_W'(1);
            cfg_dirty_reg <= 1'b0;
        end else begin
            cfg_dirty_reg <= cfg_wr;
            if (cfg_wr) begin
                case (cfg_addr)
                    CFG_PAT_LOW:      pat_reg[63:0]    <= cfg_data;
                    CFG_PAT_MID_LOW:  pat_reg[127:64]  <= cfg_data;
                    CFG_PAT_MID_HIGH: pat_reg[191:128] <= cfg_data;
                    CFG_PAT_HIGH:     pat_reg[255:192] <= cfg_data;
                    CFG_CARE_MASK:    care_reg         <= cfg_data[PAT_SLOTS-1:0];
                    CFG_PAT_LEN:      len_cfg_reg      <= cfg_data[LEN_W-1:0];
                    default: ;  // unknown index: ignored
                endcase
            end
        end
    end

    // ---------------- per-cell aligned pattern ----------------
    // Cell k holds the k-th newest byte, which lines up with pattern byte len-1-k.
    // Rebuilt every cycle from the registers; input is held off the cycle after a write.
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       cell_pat_reg  [NCELL];
    logic [NCELL-1:0] cell_care_reg;

    always_comb begin
        if (len_cfg_reg == '0) begin
            len_next = LEN_W'(1);
        end else if (len_cfg_reg > LEN_MAX) begin
            len_next = LEN_MAX;
        end else begin
            len_next = len_cfg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_align
        logic [LEN_W-1:0] slot;
        assign slot = len_next - LEN_W'(1) - LEN_W'(k);
        always_ff @(posedge aclk) begin
            cell_pat_reg[k]  <= pat_reg[slot[4:0]*8 +: 8];
            cell_care_reg[k] <= (LEN_W'(k) < len_next) && care_reg[slot[4:0]];
        end
    end

    // ---------------- cell chain ----------------
    logic        accept;
    logic        out_full;
    cell_ctrl_t  cell_ctrl;
    logic [7:0]  chain [NCELL+1];
    logic [NCELL-1:0] cell_eq;

    assign s_tready        = !out_full && !cfg_dirty_reg;
    assign accept          = s_tvalid && s_tready;
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = accept && s_tlast;
    assign chain[0]        = s_tdata;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        mbps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .byte_in  (chain[k]),
            .pat_byte (cell_pat_reg[k]),
            .care     (cell_care_reg[k]),
            .byte_out (chain[k+1]),
            .eq       (cell_eq[k])
        );
    end

    // ---------------- region bookkeeping ----------------
    logic [OFFSET_BITS-1:0] seen_reg;
    logic [OFFSET_BITS-1:0] seen_inc;
    logic [OFFSET_BITS-1:0] match_start;
    logic                   reported_reg;
    logic                   counted;
    logic                   hit;
    logic                   push;
    result_t                push_data;
    result_t                out_data;

    assign counted     = (seen_reg != '1);     // saturated count: byte not checked
    assign seen_inc    = seen_reg + OFFSET_BITS'(1);
    assign match_start = seen_inc - OFFSET_BITS'(len_reg);
    assign hit         = counted && !reported_reg
                         && (seen_inc >= OFFSET_BITS'(len_reg)) && (&cell_eq);

    // match wins over not-found on the region's last byte
    assign push             = accept && (hit || (s_tlast && !reported_reg));
    assign push_data.found  = hit;
    assign push_data.offset = hit ? OUT_OFFSET_W'(match_start) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end else begin
                if (counted) begin
                    seen_reg <= seen_inc;
                end
                if (hit) begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    mbps_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (out_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata    = out_data.offset;
    assign m_tuser[0] = out_data.found;

endmodule

// ===== hdl/mbps_cell.sv =====
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] byte_out,
    output logic       eq
);

    logic [7:0] byte_reg;

    // eq looks at the byte moving in, i.e. the window after this shift
    assign eq       = !care || (byte_in == pat_byte);
    assign byte_out = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            byte_reg <= '0;
        end else if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

endmodule

// ===== hdl/mbps_outbuf.sv =====
module mbps_outbuf
    import mbps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no push possible here: upstream is stalled while skid is busy
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/mbps_checker.sv =====
module mbps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every new result comes from a byte transaction in the previous cycle
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without input transaction");

    // not-found carries a zero offset
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero offset");

    // input held off while aligned pattern rebuilds after a register write
    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("byte accepted right after register write");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
